FILE: rtl/primitive_assembly_indexer_core_defines.svh
// Assertion helpers for the primitive assembly indexer core.
`ifndef PRIMITIVE_ASSEMBLY_INDEXER_CORE_DEFINES_SVH
`define PRIMITIVE_ASSEMBLY_INDEXER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PAI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pai_pkg.sv
package pai_pkg;

   localparam int DEF_INDEX_DEPTH       = 4096;
   localparam int DEF_VERTEX_INDEX_BITS = 16;

   // request payload layout
   localparam int ADDR_FIELD_W = 12;
   localparam int VALUE_W      = 16;
   localparam int PRIM_W       = 16;
   localparam int ADDR_LSB     = 0;
   localparam int VALUE_LSB    = ADDR_LSB + ADDR_FIELD_W;
   localparam int PRIM_LSB     = VALUE_LSB + VALUE_W;
   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_TDATA_W  = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TOPO_W     = 3;
   localparam int COUNT_W    = 17;
   localparam int POS_W      = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIM_TYPE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_INDEX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_COUNT = 2'd2;

   localparam logic [TOPO_W-1:0] TOPO_TRI_LIST   = 3'd0;
   localparam logic [TOPO_W-1:0] TOPO_TRI_STRIP  = 3'd1;
   localparam logic [TOPO_W-1:0] TOPO_TRI_FAN    = 3'd2;
   localparam logic [TOPO_W-1:0] TOPO_LINE_LIST  = 3'd3;
   localparam logic [TOPO_W-1:0] TOPO_LINE_STRIP = 3'd4;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic write;        // store an index buffer entry
      logic latch;        // capture the primitive number
      logic load_err;     // load the out-of-range result
      logic read_en;      // issue an index buffer read
      logic advance;      // step to the next corner
      logic load_corner;  // load the current corner result
   } cmd_type;

   typedef struct packed {
      logic prim_ok;
      logic last_corner;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/primitive_assembly_indexer_core.sv
// A fetch is taken in idle; the check state tests its range and reads the first corner or
// loads an error result; the fetch state loads each corner and reads the next, paced by the
// single registered read port of the index buffer and the corner counter. No request is
// taken outside idle; a finished result waits in the output register while the next is taken.
// Reset (synchronous, active high) clears control state and configuration registers;
// the index buffer is not cleared and holds unknown data until written.
`include "primitive_assembly_indexer_core_defines.svh"

module primitive_assembly_indexer_core
   import pai_pkg::*;
#(
   parameter int INDEX_DEPTH       = DEF_INDEX_DEPTH,
   parameter int VERTEX_INDEX_BITS = DEF_VERTEX_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // entry_addr[11:0], entry_value[27:12],
                                              // prim_index[43:28], zero pad
   input  logic                   req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // vertex_index[15:0]
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,  // status
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   logic    err_out;

   pai_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pai_datapath #(
      .INDEX_DEPTH       (INDEX_DEPTH),
      .VERTEX_INDEX_BITS (VERTEX_INDEX_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

   assign err_out = rsp_tvalid && (rsp_tuser == STATUS_RANGE);

   `PAI_ASSERT_NOW(a_err_is_last, err_out, rsp_tlast && rsp_tdata == '0, "bad error result")
   `PAI_ASSERT_NOW(a_load_free, cmd.load_err || cmd.load_corner, sts.out_free, "lost result")
   `PAI_ASSERT_NEXT(a_busy_after_fetch, cmd.latch, !req_tready, "request taken during a fetch")

endmodule

FILE: rtl/pai_ctrl.sv
module pai_ctrl
   import pai_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_tuser,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tuser == REQ_FETCH) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.prim_ok) begin
               state_in = ST_FETCH;
            end else if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            if (sts.out_free && sts.last_corner) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.write  = req_tvalid && req_tuser == REQ_WRITE;
            cmd.latch  = req_tvalid && req_tuser == REQ_FETCH;
         end
         ST_CHECK: begin
            // read the first corner while the range check resolves
            cmd.read_en  = sts.prim_ok;
            cmd.load_err = !sts.prim_ok && sts.out_free;
         end
         ST_FETCH: begin
            cmd.load_corner = sts.out_free;
            cmd.advance     = sts.out_free && !sts.last_corner;
            cmd.read_en     = sts.out_free && !sts.last_corner;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/pai_datapath.sv
module pai_datapath
   import pai_pkg::*;
#(
   parameter int INDEX_DEPTH       = DEF_INDEX_DEPTH,
   parameter int VERTEX_INDEX_BITS = DEF_VERTEX_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,
   input  cmd_type                cmd,
   output sts_type                sts
);

   localparam int ADDR_W  = $clog2(INDEX_DEPTH);
   localparam int STORE_W = (VERTEX_INDEX_BITS < VALUE_W) ? VERTEX_INDEX_BITS : VALUE_W;
   localparam logic [VALUE_W-1:0] VMASK = VALUE_W'((64'd1 << STORE_W) - 64'd1);
   localparam logic [COUNT_W-1:0] DEPTH_N = COUNT_W'(INDEX_DEPTH);

   function automatic logic [POS_W-1:0] pos_of(input logic [TOPO_W-1:0] topo,
                                               input logic [PRIM_W-1:0] p,
                                               input logic [1:0] k);
      logic [POS_W-1:0] pos;
      case (topo) inside
         TOPO_TRI_LIST:  pos = POS_W'({p, 1'b0}) + POS_W'(p) + POS_W'(k);
         TOPO_TRI_FAN:   pos = (k == 2'd0) ? '0 : POS_W'(p) + POS_W'(k);
         TOPO_LINE_LIST: pos = POS_W'({p, 1'b0}) + POS_W'(k);
         TOPO_TRI_STRIP, TOPO_LINE_STRIP: pos = POS_W'(p) + POS_W'(k);
         default:        pos = POS_W'(p) + POS_W'(k);
      endcase
      return pos;
   endfunction

   logic [TOPO_W-1:0]  topo_ff, topo_in;
   logic               use_idx_ff, use_idx_in;
   logic [VALUE_W-1:0] elem_count_ff, elem_count_in;

   logic [PRIM_W-1:0]  prim_ff;
   logic [1:0]         corner_ff, corner_in;

   logic [STORE_W-1:0] index_mem [INDEX_DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   logic               out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic               out_last_ff;
   logic               out_user_ff;

   logic [ADDR_FIELD_W-1:0] wr_addr;
   logic [COUNT_W-1:0]  wr_addr_ext;
   logic                wr_ok;
   logic [COUNT_W-1:0]  n_eff;
   logic [1:0]          last_k;
   logic [POS_W-1:0]    last_pos;
   logic [POS_W-1:0]    cur_pos;
   logic [POS_W-1:0]    rd_pos;
   logic [RSP_TDATA_W-1:0] corner_value;

   // configuration registers
   always_comb begin
      topo_in       = topo_ff;
      use_idx_in    = use_idx_ff;
      elem_count_in = elem_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRIM_TYPE:  topo_in       = csr_wdata[TOPO_W-1:0];
            CSR_USE_INDEX:  use_idx_in    = csr_wdata[0];
            CSR_ELEM_COUNT: elem_count_in = csr_wdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         topo_ff       <= TOPO_TRI_LIST;
         use_idx_ff    <= 1'b0;
         elem_count_ff <= '0;
      end else begin
         topo_ff       <= topo_in;
         use_idx_ff    <= use_idx_in;
         elem_count_ff <= elem_count_in;
      end
   end

   // range check: the primitive exists when the topology is valid and its highest corner lies below the count
   assign n_eff    = (use_idx_ff && {1'b0, elem_count_ff} > DEPTH_N) ?
                     DEPTH_N : {1'b0, elem_count_ff};
   assign last_k   = (topo_ff == TOPO_LINE_LIST || topo_ff == TOPO_LINE_STRIP) ? 2'd1 : 2'd2;
   assign last_pos = pos_of(topo_ff, prim_ff, last_k);
   assign cur_pos  = pos_of(topo_ff, prim_ff, corner_ff);
   assign rd_pos   = cmd.advance ? pos_of(topo_ff, prim_ff, corner_ff + 2'd1) : cur_pos;

   assign sts.prim_ok     = (topo_ff <= TOPO_LINE_STRIP) && (last_pos < POS_W'(n_eff));
   assign sts.last_corner = (corner_ff == last_k);
   assign sts.out_free    = !out_valid_ff || rsp_tready;

   always_comb begin
      corner_in = corner_ff;
      if (cmd.latch) begin
         corner_in = '0;
      end else if (cmd.advance) begin
         corner_in = corner_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
      end else begin
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         prim_ff <= req_tdata[PRIM_LSB +: PRIM_W];
      end
   end

   // index buffer: one write port, one registered read port
   assign wr_addr     = req_tdata[ADDR_LSB +: ADDR_FIELD_W];
   assign wr_addr_ext = COUNT_W'(wr_addr);
   assign wr_ok       = wr_addr_ext < DEPTH_N;

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         index_mem[wr_addr_ext[ADDR_W-1:0]] <= req_tdata[VALUE_LSB +: STORE_W];
      end
      if (cmd.read_en) begin
         rd_data_ff <= index_mem[rd_pos[ADDR_W-1:0]];
      end
   end

   assign corner_value = use_idx_ff ? RSP_TDATA_W'(rd_data_ff) :
                         (cur_pos[RSP_TDATA_W-1:0] & VMASK);

   // result register: holds a finished request while the next one is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_err || cmd.load_corner) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         out_data_ff <= '0;
         out_last_ff <= 1'b1;
         out_user_ff <= STATUS_RANGE;
      end else if (cmd.load_corner) begin
         out_data_ff <= corner_value;
         out_last_ff <= sts.last_corner;
         out_user_ff <= STATUS_OK;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

FILE: bench/primitive_assembly_indexer_checker.sv
module primitive_assembly_indexer_checker
   import pai_pkg::*;
#(
   parameter int INDEX_DEPTH       = DEF_INDEX_DEPTH,
   parameter int VERTEX_INDEX_BITS = DEF_VERTEX_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     results_outstanding,
   output int                     writes_seen,
   output int                     fetches_seen,
   output int                     range_seen,
   output int                     results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 50;
   localparam logic [31:0] VERTEX_MASK =
      (VERTEX_INDEX_BITS >= 32) ? 32'hFFFF_FFFF : (32'd1 << VERTEX_INDEX_BITS) - 32'd1;

   typedef struct packed {
      logic                   status;
      logic [RSP_TDATA_W-1:0] vertex;
      logic                   last;
   } corner_type;

   corner_type             expected_corners[$];
   logic [TOPO_W-1:0]      topology;
   logic                   indexed;
   logic [CSR_DATA_W-1:0]  element_count;
   logic [VALUE_W-1:0]     index_store [INDEX_DEPTH];

   function automatic int unsigned primitives_for(input logic [TOPO_W-1:0] topo,
                                                  input int unsigned n);
      case (topo) inside
         TOPO_TRI_LIST:                return n / 3;
         TOPO_TRI_STRIP, TOPO_TRI_FAN: return (n < 3) ? 0 : n - 2;
         TOPO_LINE_LIST:               return n / 2;
         TOPO_LINE_STRIP:              return (n < 2) ? 0 : n - 1;
         default:                      return 0;
      endcase
   endfunction

   function automatic logic [RSP_TDATA_W-1:0] vertex_at(input int unsigned pos);
      if (!indexed) begin
         return RSP_TDATA_W'(pos & VERTEX_MASK);
      end
      if (pos >= INDEX_DEPTH) begin
         return '0;
      end
      return RSP_TDATA_W'(32'(index_store[pos]) & VERTEX_MASK);
   endfunction

   function automatic void predict_corners(input logic [PRIM_W-1:0] prim);
      int unsigned n;
      int unsigned p;
      int unsigned corners;
      int unsigned pos [3];
      corner_type  r;
      n = element_count;
      // indexed mode never reaches past the buffer
      if (indexed && n > INDEX_DEPTH) begin
         n = INDEX_DEPTH;
      end
      p = prim;
      if (p >= primitives_for(topology, n)) begin
         r.status = STATUS_RANGE;
         r.vertex = '0;
         r.last   = 1'b1;
         expected_corners = {expected_corners, r};
         range_seen++;
         return;
      end
      corners = 3;
      case (topology)
         TOPO_TRI_LIST:  pos = '{3 * p, 3 * p + 1, 3 * p + 2};
         TOPO_TRI_STRIP: pos = '{p, p + 1, p + 2};
         TOPO_TRI_FAN:   pos = '{0, p + 1, p + 2};
         TOPO_LINE_LIST: begin
            pos     = '{2 * p, 2 * p + 1, 0};
            corners = 2;
         end
         default: begin
            pos     = '{p, p + 1, 0};
            corners = 2;
         end
      endcase
      for (int k = 0; k < corners; k++) begin
         r.status = STATUS_OK;
         r.vertex = vertex_at(pos[k]);
         r.last   = (k == corners - 1);
         expected_corners = {expected_corners, r};
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      corner_type want;
      if (reset) begin
         expected_corners.delete();
         topology       = TOPO_TRI_LIST;
         indexed        = 1'b0;
         element_count  = '0;
         mismatch_count = 0;
         writes_seen    = 0;
         fetches_seen   = 0;
         range_seen     = 0;
         results_seen   = 0;
      end else begin
         // results first: a request taken at this edge cannot answer at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_corners.size() == 0) begin
               report_mismatch($sformatf("result with no request pending (vertex 0x%0h)",
                                         rsp_tdata));
            end else begin
               want = expected_corners.pop_front();
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status expected %0b, got %0b",
                                            want.status, rsp_tuser));
               end
               if (rsp_tdata !== want.vertex) begin
                  report_mismatch($sformatf("vertex expected 0x%0h, got 0x%0h",
                                            want.vertex, rsp_tdata));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last expected %0b, got %0b",
                                            want.last, rsp_tlast));
               end
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_WRITE) begin
               index_store[req_tdata[ADDR_LSB +: ADDR_FIELD_W]] = req_tdata[VALUE_LSB +: VALUE_W];
               writes_seen++;
            end else begin
               predict_corners(req_tdata[PRIM_LSB +: PRIM_W]);
               fetches_seen++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PRIM_TYPE:  topology      = csr_wdata[TOPO_W-1:0];
               CSR_USE_INDEX:  indexed       = csr_wdata[0];
               CSR_ELEM_COUNT: element_count = csr_wdata;
               default: ;
            endcase
         end
      end
      results_outstanding <= expected_corners.size();
   end

endmodule

FILE: bench/primitive_assembly_indexer_core_tb.sv
module primitive_assembly_indexer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pai_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 1000;
   localparam int RANDOM_ITEMS  = 260;
   localparam int RSP_HOLDOFF   = 150;
   localparam int INDEX_DEPTH   = DEF_INDEX_DEPTH;
   localparam int FILL_LOW      = 32;
   localparam int FILL_HIGH     = 8;
   localparam int SAFE_PRIMS    = 8;
   localparam logic [TOPO_W-1:0] TOPO_LAST_CODE = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // entry_addr[11:0], entry_value[27:12],
                                            // prim_index[43:28], zero pad
   logic                   req_tuser = REQ_WRITE;  // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // vertex_index[15:0]
   logic                   rsp_tlast;
   logic                   rsp_tuser;  // status
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_PRIM_TYPE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int results_outstanding;
   int writes_seen;
   int fetches_seen;
   int range_seen;
   int results_seen;

   logic [TOPO_W-1:0]     cur_topo = TOPO_TRI_LIST;
   logic                  cur_indexed = 1'b0;
   logic [CSR_DATA_W-1:0] cur_count = '0;
   bit                    req_burst = 1'b0;
   bit                    rsp_burst = 1'b0;
   int                    rsp_holdoff = 0;
   int                    settings_used = 0;
   int                    idle_cycles = 0;
   bit                    entry_written [INDEX_DEPTH];

   primitive_assembly_indexer_core u_dut (.*);

   primitive_assembly_indexer_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned prims_in_use();
      int unsigned n;
      n = cur_count;
      if (cur_indexed && n > INDEX_DEPTH) begin
         n = INDEX_DEPTH;
      end
      case (cur_topo) inside
         TOPO_TRI_LIST:                return n / 3;
         TOPO_TRI_STRIP, TOPO_TRI_FAN: return (n < 3) ? 0 : n - 2;
         TOPO_LINE_LIST:               return n / 2;
         TOPO_LINE_STRIP:              return (n < 2) ? 0 : n - 1;
         default:                      return 0;
      endcase
   endfunction

   // an indexed fetch in range may only touch entries already written
   function automatic bit fetch_is_safe(input logic [PRIM_W-1:0] prim);
      int unsigned p;
      int unsigned first;
      int unsigned span;
      bit          ok;
      p = prim;
      if (!cur_indexed || p >= prims_in_use()) begin
         return 1'b1;
      end
      span  = 3;
      first = p;
      case (cur_topo)
         TOPO_TRI_LIST:  first = 3 * p;
         TOPO_LINE_LIST: begin
            first = 2 * p;
            span  = 2;
         end
         TOPO_LINE_STRIP: span = 2;
         default: ;
      endcase
      ok = (cur_topo != TOPO_TRI_FAN) || entry_written[0];
      for (int unsigned i = 0; i < span; i++) begin
         ok = ok && entry_written[first + i];
      end
      return ok;
   endfunction

   task automatic push_request(input logic kind, input logic [ADDR_FIELD_W-1:0] addr,
                               input logic [VALUE_W-1:0] value, input logic [PRIM_W-1:0] prim);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W - PRIM_LSB - PRIM_W){1'b0}}, prim, value, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_entry(input logic [ADDR_FIELD_W-1:0] addr,
                              input logic [VALUE_W-1:0] value);
      entry_written[addr] = 1'b1;
      // prim field is don't-care on a write; keep it toggling
      push_request(REQ_WRITE, addr, value, PRIM_W'($urandom));
   endtask

   task automatic fetch_prim(input logic [PRIM_W-1:0] prim);
      push_request(REQ_FETCH, ADDR_FIELD_W'($urandom), VALUE_W'($urandom), prim);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      // a trailing write may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [TOPO_W-1:0] topo, input logic indexed,
                           input logic [CSR_DATA_W-1:0] count);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_PRIM_TYPE;
      csr_wdata <= CSR_DATA_W'(topo);
      @(posedge clock);
      csr_index <= CSR_USE_INDEX;
      csr_wdata <= CSR_DATA_W'(indexed);
      @(posedge clock);
      csr_index <= CSR_ELEM_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_topo    = topo;
      cur_indexed = indexed;
      cur_count   = count;
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no request, result or register write for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (rsp_holdoff != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_holdoff) @(posedge clock);
            rsp_holdoff = 0;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int                    random_sent;
      int                    phase_len;
      int                    sel;
      int unsigned           total;
      logic [PRIM_W-1:0]     prim;
      logic [TOPO_W-1:0]     topo;
      logic [CSR_DATA_W-1:0] count;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill both ends of the buffer; indexed fetches stay on written entries
      req_burst = 1'b1;
      rsp_burst = 1'b1;
      for (int a = 0; a < FILL_LOW; a++) begin
         write_entry(ADDR_FIELD_W'(a), VALUE_W'($urandom));
      end
      for (int a = INDEX_DEPTH - FILL_HIGH; a < INDEX_DEPTH; a++) begin
         write_entry(ADDR_FIELD_W'(a), VALUE_W'($urandom));
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;

      write_entry('0, '1);
      write_entry('1, '0);

      // generated triangles at full count: first, last whole one, one past, top value
      set_mode(TOPO_TRI_LIST, 1'b0, '1);
      fetch_prim(16'd0);
      fetch_prim(16'd21844);
      fetch_prim(16'd21845);
      fetch_prim('1);

      set_mode(TOPO_TRI_FAN, 1'b0, 16'd3);
      fetch_prim(16'd0);
      fetch_prim(16'd1);

      // indexed strip: count clamps to the buffer depth
      set_mode(TOPO_TRI_STRIP, 1'b1, '1);
      fetch_prim(16'd0);
      fetch_prim(16'd4093);
      fetch_prim(16'd4094);

      set_mode(TOPO_LINE_LIST, 1'b1, '0);
      fetch_prim(16'd0);

      set_mode(TOPO_LINE_STRIP, 1'b1, '1);
      fetch_prim(16'd0);
      fetch_prim(16'd4094);
      fetch_prim(16'd4095);

      set_mode(TOPO_LINE_LIST, 1'b0, '1);
      fetch_prim(16'd32766);

      set_mode(TOPO_LINE_STRIP, 1'b0, 16'd1);
      fetch_prim(16'd0);

      set_mode(TOPO_TRI_STRIP, 1'b0, 16'd2);
      fetch_prim(16'd0);

      // unused topology code answers every fetch as out of range
      set_mode(TOPO_LAST_CODE, 1'b0, '1);
      fetch_prim(16'd0);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            topo = TOPO_W'($urandom_range(TOPO_LINE_STRIP + 1, TOPO_LAST_CODE));
         end else begin
            topo = TOPO_W'($urandom_range(TOPO_TRI_LIST, TOPO_LINE_STRIP));
         end
         case ($urandom_range(0, 5))
            0:       count = CSR_DATA_W'($urandom_range(0, 4));
            1:       count = CSR_DATA_W'(INDEX_DEPTH - 1 + $urandom_range(0, 2));
            2:       count = '1;
            3:       count = CSR_DATA_W'($urandom);
            default: count = CSR_DATA_W'($urandom_range(5, 60));
         endcase
         set_mode(topo, 1'($urandom_range(0, 1)), count);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         // hold the result side off long enough for requests to back up
         if (random_sent == 0) begin
            req_burst   = 1'b1;
            rsp_holdoff = RSP_HOLDOFF;
         end
         phase_len = $urandom_range(20, 45);
         repeat (phase_len) begin
            if ($urandom_range(0, 3) == 0) begin
               write_entry(ADDR_FIELD_W'($urandom), VALUE_W'($urandom));
            end else begin
               total = prims_in_use();
               sel   = $urandom_range(0, 9);
               if (total != 0 && sel < 6) begin
                  prim = PRIM_W'($urandom_range(0, total - 1));
               end else if (sel < 8) begin
                  prim = (total == 0) ? '0 : PRIM_W'(total - $urandom_range(0, 1));
               end else begin
                  prim = PRIM_W'($urandom);
               end
               // fall back to a low primitive whose entries are filled
               if (!fetch_is_safe(prim)) begin
                  prim = PRIM_W'($urandom_range(0, (total < SAFE_PRIMS) ?
                                                   total - 1 : SAFE_PRIMS - 1));
               end
               fetch_prim(prim);
            end
         end
         random_sent += phase_len;
      end

      drain_results();

      $display("Covered %0d index writes and %0d fetches (%0d out of range) over %0d settings",
               writes_seen, fetches_seen, range_seen, settings_used);
      $display("Checked %0d results, including a %0d-cycle output stall with input backpressure",
               results_seen, RSP_HOLDOFF);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pai_pkg.sv
rtl/pai_ctrl.sv
rtl/pai_datapath.sv
rtl/primitive_assembly_indexer_core.sv
bench/primitive_assembly_indexer_checker.sv
bench/primitive_assembly_indexer_core_tb.sv
